>>> hdl/sha_pkg.sv
package sha_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    typedef struct packed {
        logic [31:0] data;
        logic        digest;
    } t_qword;

    typedef enum logic [1:0] {F_IN, F_P80, F_ZERO, F_LEN} t_fstate;
    typedef enum logic [1:0] {B_ROUND, B_ADD, B_OUT} t_bstate;

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] h_init(input logic [2:0] idx);
        h_init = H_INIT[(7 - idx) * 32 +: 32];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] kconst(input logic [5:0] r);
        case (r)
            6'd0:  kconst = 32'h428a2f98; 6'd1:  kconst = 32'h71374491;
            6'd2:  kconst = 32'hb5c0fbcf; 6'd3:  kconst = 32'he9b5dba5;
            6'd4:  kconst = 32'h3956c25b; 6'd5:  kconst = 32'h59f111f1;
            6'd6:  kconst = 32'h923f82a4; 6'd7:  kconst = 32'hab1c5ed5;
            6'd8:  kconst = 32'hd807aa98; 6'd9:  kconst = 32'h12835b01;
            6'd10: kconst = 32'h243185be; 6'd11: kconst = 32'h550c7dc3;
            6'd12: kconst = 32'h72be5d74; 6'd13: kconst = 32'h80deb1fe;
            6'd14: kconst = 32'h9bdc06a7; 6'd15: kconst = 32'hc19bf174;
            6'd16: kconst = 32'he49b69c1; 6'd17: kconst = 32'hefbe4786;
            6'd18: kconst = 32'h0fc19dc6; 6'd19: kconst = 32'h240ca1cc;
            6'd20: kconst = 32'h2de92c6f; 6'd21: kconst = 32'h4a7484aa;
            6'd22: kconst = 32'h5cb0a9dc; 6'd23: kconst = 32'h76f988da;
            6'd24: kconst = 32'h983e5152; 6'd25: kconst = 32'ha831c66d;
            6'd26: kconst = 32'hb00327c8; 6'd27: kconst = 32'hbf597fc7;
            6'd28: kconst = 32'hc6e00bf3; 6'd29: kconst = 32'hd5a79147;
            6'd30: kconst = 32'h06ca6351; 6'd31: kconst = 32'h14292967;
            6'd32: kconst = 32'h27b70a85; 6'd33: kconst = 32'h2e1b2138;
            6'd34: kconst = 32'h4d2c6dfc; 6'd35: kconst = 32'h53380d13;
            6'd36: kconst = 32'h650a7354; 6'd37: kconst = 32'h766a0abb;
            6'd38: kconst = 32'h81c2c92e; 6'd39: kconst = 32'h92722c85;
            6'd40: kconst = 32'ha2bfe8a1; 6'd41: kconst = 32'ha81a664b;
            6'd42: kconst = 32'hc24b8b70; 6'd43: kconst = 32'hc76c51a3;
            6'd44: kconst = 32'hd192e819; 6'd45: kconst = 32'hd6990624;
            6'd46: kconst = 32'hf40e3585; 6'd47: kconst = 32'h106aa070;
            6'd48: kconst = 32'h19a4c116; 6'd49: kconst = 32'h1e376c08;
            6'd50: kconst = 32'h2748774c; 6'd51: kconst = 32'h34b0bcb5;
            6'd52: kconst = 32'h391c0cb3; 6'd53: kconst = 32'h4ed8aa4a;
            6'd54: kconst = 32'h5b9cca4f; 6'd55: kconst = 32'h682e6ff3;
            6'd56: kconst = 32'h748f82ee; 6'd57: kconst = 32'h78a5636f;
            6'd58: kconst = 32'h84c87814; 6'd59: kconst = 32'h8cc70208;
            6'd60: kconst = 32'h90befffa; 6'd61: kconst = 32'ha4506ceb;
            6'd62: kconst = 32'hbef9a3f7; 6'd63: kconst = 32'hc67178f2;
            default: kconst = 32'h0;
        endcase
    endfunction

endpackage

>>> hdl/sha_front.sv
module sha_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    input  logic          i_byte_present,
    input  logic          i_end_of_message,
    output logic          o_full,
    output logic          o_q_push,
    output sha_pkg::t_qword o_q_word,
    input  logic          i_q_full
);
    import sha_pkg::*;

    t_fstate     r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [23:0] r_acc, n_acc;
    logic [2:0]  r_lcnt, n_lcnt;
    logic        step;
    logic [7:0]  step_byte;
    logic        word_blocked;

    assign word_blocked = (r_fill[1:0] == 2'd3) && i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IN;
            r_fill  <= '0;
            r_bits  <= '0;
            r_lcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_lcnt  <= n_lcnt;
        end
        r_acc <= n_acc;
    end

    always_comb begin
        n_state   = r_state;
        n_bits    = r_bits;
        n_lcnt    = r_lcnt;
        step      = 1'b0;
        step_byte = 8'h00;
        o_full    = (r_state != F_IN) || word_blocked;
        case (r_state)
            F_IN: begin
                if (i_push && !o_full) begin
                    step      = i_byte_present;
                    step_byte = i_data_byte;
                    if (i_byte_present) n_bits = r_bits + 64'd8;
                    if (i_end_of_message) n_state = F_P80;
                end
            end
            F_P80: begin
                if (!word_blocked) begin
                    step      = 1'b1;
                    step_byte = 8'h80;
                    n_state   = F_ZERO;
                end
            end
            F_ZERO: begin
                if (r_fill == 6'd56) begin
                    n_state = F_LEN;
                end else if (!word_blocked) begin
                    step = 1'b1;
                end
            end
            F_LEN: begin
                if (!word_blocked) begin
                    step      = 1'b1;
                    step_byte = r_bits[63:56];
                    n_bits    = {r_bits[55:0], 8'h00};
                    n_lcnt    = r_lcnt + 3'd1;
                    if (r_lcnt == 3'd7) n_state = F_IN;
                end
            end
            default: n_state = F_IN;
        endcase

        n_fill = step ? r_fill + 6'd1 : r_fill;
        n_acc  = step ? {r_acc[15:0], step_byte} : r_acc;
        o_q_push          = step && (r_fill[1:0] == 2'd3);
        o_q_word.data     = {r_acc, step_byte};
        o_q_word.digest   = (r_state == F_LEN) && (r_lcnt == 3'd7);
    end

endmodule

>>> hdl/sha_fifo.sv
module sha_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sha_pkg::t_qword i_word,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sha_pkg::t_qword o_word
);
    import sha_pkg::*;

    t_qword       r_mem [QDepth];
    logic [QAw-1:0] r_wp, r_rp;
    logic [QAw:0]   r_cnt;

    assign o_full  = (r_cnt == (QAw+1)'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAw+1)'(i_push) - (QAw+1)'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_word;
    end

endmodule

>>> hdl/sha_core.sv
module sha_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  sha_pkg::t_qword i_q_word,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [31:0]   o_digest_word,
    output logic [2:0]    o_word_index,
    output logic          o_final_word
);
    import sha_pkg::*;

    t_bstate     r_state, n_state;
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;
    logic        r_dig;
    logic        r_ovalid;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [31:0] r_wnext;
    logic [31:0] wt, wnext, t1, t2, s0, s1;
    logic        adv, load_out;

    assign o_empty = !r_ovalid;
    assign adv      = (r_state == B_ROUND) && (r_rnd[5:4] != 2'b00 || i_q_valid);
    assign o_q_pop  = (r_state == B_ROUND) && (r_rnd[5:4] == 2'b00) && i_q_valid;
    assign load_out = (r_state == B_OUT) && (!r_ovalid || i_pop);

    // schedule word for the next round is computed ahead and registered in r_wnext
    always_comb begin
        s0 = ror(r_w[2], 7) ^ ror(r_w[2], 18) ^ (r_w[2] >> 3);
        s1 = ror(r_w[15], 17) ^ ror(r_w[15], 19) ^ (r_w[15] >> 10);
        wnext = r_w[1] + s0 + r_w[10] + s1;
        wt = (r_rnd[5:4] == 2'b00) ? i_q_word.data : r_wnext;
        t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + kconst(r_rnd) + wt;
        t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_ROUND: if (adv && r_rnd == 6'd63) n_state = B_ADD;
            B_ADD:   n_state = r_dig ? B_OUT : B_ROUND;
            B_OUT:   if (load_out && r_idx == 3'd7) n_state = B_ROUND;
            default: n_state = B_ROUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_ROUND;
            r_rnd    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= h_init(3'(i));
                r_v[i] <= h_init(3'(i));
            end
        end else begin
            r_state <= n_state;
            if (load_out)   r_ovalid <= 1'b1;
            else if (i_pop) r_ovalid <= 1'b0;
            case (r_state)
                B_ROUND: begin
                    if (adv) begin
                        r_rnd  <= r_rnd + 6'd1;
                        r_v[0] <= t1 + t2;
                        r_v[4] <= r_v[3] + t1;
                        for (int i = 1; i < 8; i++) begin
                            if (i != 4) r_v[i] <= r_v[i-1];
                        end
                    end
                end
                B_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                        r_v[i] <= r_h[i] + r_v[i];
                    end
                    r_idx <= '0;
                end
                B_OUT: begin
                    if (load_out) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= h_init(3'(i));
                                r_v[i] <= h_init(3'(i));
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (adv) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wt;
            r_wnext <= wnext;
        end
        if (o_q_pop && r_rnd == 6'd15) r_dig <= i_q_word.digest;
        if (load_out) begin
            o_digest_word <= r_h[r_idx];
            o_word_index  <= r_idx;
            o_final_word  <= (r_idx == 3'd7);
        end
    end

endmodule

>>> hdl/sha256_hash_engine_unit.sv
// SHA-256 engine, one message byte per input transaction.
// Input: drive i_data_byte / i_byte_present / i_end_of_message with i_push;
// the transaction is taken on a clock edge where i_push is high and o_full low.
// An item with i_byte_present low adds nothing; one with i_end_of_message high
// closes the message (its byte, if present, is hashed first).
// Output: while o_empty is low the oldest digest word sits on o_digest_word,
// o_word_index and o_final_word; i_pop takes it. Eight words per message.
// Bytes are taken one per cycle while the 4-entry word queue has room; the
// compression core runs one round per cycle (64 rounds plus an add step per
// block, the first 16 rounds paced by the queue). After the closing
// transaction o_full stays high while the pad and length bytes are fed in,
// longer while the queue is full. Digest word 0 is loaded into the output
// register in the output phase after the last block's add step, then one
// word per cycle while the receiver pops.
// A stalled receiver holds the core in its output phase; the front end keeps
// taking bytes until the queue fills, then raises o_full.
// Synchronous reset (i_rst_n low) loads the initial hash values, clears the
// byte and bit counters and empties the queue and output register.
module sha256_hash_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_final_word
);
    import sha_pkg::*;

    logic   q_push, q_full, q_pop, q_valid;
    t_qword q_in, q_out;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_push, .i_data_byte, .i_byte_present,
        .i_end_of_message, .o_full,
        .o_q_push(q_push), .o_q_word(q_in), .i_q_full(q_full)
    );

    sha_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(q_push), .i_word(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_word(q_out)
    );

    sha_core u_core (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_q_word(q_out), .o_q_pop(q_pop),
        .o_empty, .i_pop, .o_digest_word, .o_word_index, .o_final_word
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full && !q_pop)) else $error("word queue overflow");

    a_final_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_final_word == (o_word_index == 3'd7)))
        else $error("final_word mismatch");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_final_word) |=> (o_empty ||
        o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word order broken");

endmodule
